>>> rtl/icmp6_mop_pkg.sv
// shared types, codes and helpers for the icmpv6 message and option parser
package icmp6_mop_pkg;

    localparam logic [15:0] MAX_MESSAGE_BYTES = 16'hFFFF;
    localparam logic [15:0] POS_MAX           = 16'hFFFF;
    localparam logic [15:0] MIN_MESSAGE_BYTES = 16'd4;
    localparam logic [15:0] UNIT_BYTES        = 16'd8;
    localparam logic [15:0] MIN_OPTION_ROOM   = 16'd2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [7:0] TYPE_ERR_FIRST  = 8'd1;
    localparam logic [7:0] TYPE_ERR_LAST   = 8'd4;
    localparam logic [7:0] TYPE_ECHO_REQ   = 8'd128;
    localparam logic [7:0] TYPE_ECHO_REPLY = 8'd129;
    localparam logic [7:0] TYPE_RS         = 8'd133;
    localparam logic [7:0] TYPE_RA         = 8'd134;
    localparam logic [7:0] TYPE_NS         = 8'd135;
    localparam logic [7:0] TYPE_NA         = 8'd136;
    localparam logic [7:0] TYPE_REDIRECT   = 8'd137;

    localparam logic [1:0] KIND_MESSAGE = 2'd0;
    localparam logic [1:0] KIND_OPTION  = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [2:0] STATUS_PAYLOAD      = 3'd0;
    localparam logic [2:0] STATUS_OPTIONS      = 3'd1;
    localparam logic [2:0] STATUS_UNSUPPORTED  = 3'd2;
    localparam logic [2:0] STATUS_SHORT_HEADER = 3'd3;
    localparam logic [2:0] STATUS_SHORT_MIN    = 3'd4;

    localparam logic [1:0] REASON_NONE    = 2'd0;
    localparam logic [1:0] REASON_ZERO    = 2'd1;
    localparam logic [1:0] REASON_OVERRUN = 2'd2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] message_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [2:0]  message_status;
        logic [7:0]  message_type;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
        logic [7:0]  option_type;
        logic [15:0] option_offset;
        logic [10:0] option_length;
        logic [1:0]  end_reason;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    rec0;
        result_t    rec1;
    } push_t;

    function automatic logic [5:0] nd_header_size(logic [7:0] t);
        logic [5:0] h;
        case (t)
            TYPE_RS:       h = 6'd8;
            TYPE_RA:       h = 6'd16;
            TYPE_NS:       h = 6'd24;
            TYPE_NA:       h = 6'd24;
            TYPE_REDIRECT: h = 6'd40;
            default:       h = 6'd0;
        endcase
        return h;
    endfunction

    function automatic result_t end_record(logic [1:0] reason);
        result_t r;
        r             = '0;
        r.record_kind = KIND_END;
        r.end_reason  = reason;
        r.last_result = 1'b1;
        return r;
    endfunction

endpackage

>>> rtl/icmp6_mop_core.sv
// parse state and per-byte record generation
module icmp6_mop_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  icmp6_mop_pkg::in_item_t item,
    output icmp6_mop_pkg::push_t    push
);
    import icmp6_mop_pkg::*;

    logic [15:0] byte_pos_reg, byte_pos_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] noo_reg, noo_next;
    logic [7:0]  opt_type_reg, opt_type_next;
    logic        walk_reg, walk_next;

    logic [15:0] len_sat;
    logic [15:0] hdr;
    logic [15:0] len_rem;
    logic [15:0] pos_inc;
    logic [10:0] olen;
    logic [15:0] rem_after;
    result_t     msg_rec;
    result_t     opt_rec;

    always_comb
    begin
        byte_pos_next = byte_pos_reg;
        rem_next      = rem_reg;
        noo_next      = noo_reg;
        opt_type_next = opt_type_reg;
        walk_next     = walk_reg;
        push          = '0;
        msg_rec       = '0;
        opt_rec       = '0;
        len_sat   = (item.message_length > MAX_MESSAGE_BYTES) ? MAX_MESSAGE_BYTES
                                                             : item.message_length;
        hdr       = {10'd0, nd_header_size(item.data_byte)};
        len_rem   = len_sat - hdr;
        pos_inc   = (byte_pos_reg == POS_MAX) ? byte_pos_reg : byte_pos_reg + 16'd1;
        olen      = {item.data_byte, 3'b000};
        rem_after = rem_reg - {5'd0, olen};
        if (fire)
        begin
            if (item.first_byte)
            begin
                byte_pos_next        = '0;
                walk_next            = 1'b0;
                msg_rec.record_kind  = KIND_MESSAGE;
                msg_rec.message_type = item.data_byte;
                if (len_sat < MIN_MESSAGE_BYTES)
                begin
                    msg_rec.message_status = STATUS_SHORT_MIN;
                end
                else if (item.data_byte inside {[TYPE_ERR_FIRST:TYPE_ERR_LAST],
                                                TYPE_ECHO_REQ, TYPE_ECHO_REPLY})
                begin
                    if (len_sat < UNIT_BYTES)
                    begin
                        msg_rec.message_status = STATUS_SHORT_HEADER;
                    end
                    else
                    begin
                        msg_rec.message_status = STATUS_PAYLOAD;
                        msg_rec.payload_offset = UNIT_BYTES;
                        msg_rec.payload_length = len_sat - UNIT_BYTES;
                    end
                end
                else if (hdr != '0)
                begin
                    if (len_sat < hdr)
                    begin
                        msg_rec.message_status = STATUS_SHORT_HEADER;
                    end
                    else
                    begin
                        msg_rec.message_status = STATUS_OPTIONS;
                        noo_next               = hdr;
                        rem_next               = len_rem;
                        walk_next              = 1'b1;
                    end
                end
                else
                begin
                    msg_rec.message_status = STATUS_UNSUPPORTED;
                end
                push.rec0 = msg_rec;
                push.num  = 2'd1;
                if (!walk_next || (len_rem < MIN_OPTION_ROOM) || item.last_byte)
                begin
                    push.rec1 = end_record(REASON_NONE);
                    push.num  = 2'd2;
                    walk_next = 1'b0;
                end
            end
            else
            begin
                byte_pos_next = pos_inc;
                if (walk_reg)
                begin
                    if (pos_inc == noo_reg)
                    begin
                        opt_type_next = item.data_byte;
                    end
                    else if ({1'b0, pos_inc} == ({1'b0, noo_reg} + 17'd1))
                    begin
                        if (item.data_byte == 8'd0)
                        begin
                            push.rec0 = end_record(REASON_ZERO);
                            push.num  = 2'd1;
                            walk_next = 1'b0;
                        end
                        else if ({5'd0, olen} > rem_reg)
                        begin
                            push.rec0 = end_record(REASON_OVERRUN);
                            push.num  = 2'd1;
                            walk_next = 1'b0;
                        end
                        else
                        begin
                            opt_rec.record_kind   = KIND_OPTION;
                            opt_rec.option_type   = opt_type_reg;
                            opt_rec.option_offset = noo_reg;
                            opt_rec.option_length = olen;
                            push.rec0             = opt_rec;
                            push.num              = 2'd1;
                            noo_next              = noo_reg + {5'd0, olen};
                            rem_next              = rem_after;
                            if (rem_after < MIN_OPTION_ROOM)
                            begin
                                push.rec1 = end_record(REASON_NONE);
                                push.num  = 2'd2;
                                walk_next = 1'b0;
                            end
                        end
                    end
                    if (item.last_byte && walk_next)
                    begin
                        if (push.num == 2'd0)
                        begin
                            push.rec0 = end_record(REASON_NONE);
                        end
                        else
                        begin
                            push.rec1 = end_record(REASON_NONE);
                        end
                        push.num  = push.num + 2'd1;
                        walk_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            rem_reg      <= '0;
            noo_reg      <= '0;
            opt_type_reg <= '0;
            walk_reg     <= 1'b0;
        end
        else
        begin
            byte_pos_reg <= byte_pos_next;
            rem_reg      <= rem_next;
            noo_reg      <= noo_next;
            opt_type_reg <= opt_type_next;
            walk_reg     <= walk_next;
        end
    end

    a_second_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num == 2'd2) |-> (push.rec1.record_kind == KIND_END && push.rec1.last_result))
        else $error("second record of a byte is not an end record");

    a_end_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num == 2'd1 && push.rec0.record_kind == KIND_END) |-> !walk_next)
        else $error("walk still active after end record");

    a_walk_moves_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(walk_reg) || $fell(walk_reg)) |-> $past(fire))
        else $error("walk state changed without a request");

endmodule

>>> rtl/icmp6_mop_queue.sv
// result queue taking up to two records per cycle and releasing one while rec_ready is high
module icmp6_mop_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  icmp6_mop_pkg::push_t    push,
    output logic                   room,
    output logic                   rec_valid,
    input  logic                   rec_ready,
    output icmp6_mop_pkg::result_t  rec
);
    import icmp6_mop_pkg::*;

    result_t            q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               pop;

    assign rec_valid = (count_reg != '0);
    assign rec       = q_reg[rd_ptr_reg];
    assign pop       = rec_valid && rec_ready;
    assign room      = (count_reg <= QCNT_W'(QDEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.num) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= push.rec0;
        end
        if (push.num == 2'd2)
        begin
            q_reg[wr_ptr_reg + QPTR_W'(1)] <= push.rec1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0) |-> (count_reg <= QCNT_W'(QDEPTH - 2)))
        else $error("records pushed without room");

endmodule

>>> rtl/icmpv6_message_option_parser_top.sv
// top level: request register, parser core and result queue
//
// channel  dir  handshake                payload
// item     in   item_valid / item_ready  in_item_t (one message byte)
// rec      out  rec_valid / rec_ready    result_t (message, option or end record)
//
// one byte per cycle unless stalled; a byte is parsed from the request register
// a byte yields zero to two records, queued four deep, popped one per ready cycle
// the parse stage holds while fewer than two queue slots are free
// rst_n clears the walk state, the request valid flag and the queue pointers and count
module icmpv6_message_option_parser_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  icmp6_mop_pkg::in_item_t item,
    output logic                   rec_valid,
    input  logic                   rec_ready,
    output icmp6_mop_pkg::result_t  rec
);
    import icmp6_mop_pkg::*;

    in_item_t item_reg;
    logic     item_valid_reg, item_valid_next;
    logic     room;
    logic     fire;
    push_t    push;

    assign fire            = item_valid_reg && room;
    assign item_ready      = !item_valid_reg || fire;
    assign item_valid_next = (item_valid && item_ready) || (item_valid_reg && !fire);

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    icmp6_mop_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .push  (push)
    );

    icmp6_mop_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

endmodule

>>> sim/icmpv6_message_option_parser_top_tb.sv
`timescale 1ns / 1ps
// icmpv6 message/option parser testbench: byte streams in, records checked against a model or fixed lists
module icmpv6_message_option_parser_top_tb;
    import icmp6_mop_pkg::*;

    localparam int RANDOM_ITEMS     = 1800;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 32;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int IDLE_PERCENT     = 18;
    localparam int CALM_FIRST       = 700;
    localparam int CALM_LAST        = 1100;

    typedef struct packed {
        in_item_t   item;
        logic       typed;
        logic [1:0] count;
        result_t    rec0;
        result_t    rec1;
    } request_t;

    logic     clk        = 1'b0;
    logic     rst_n      = 1'b0;
    logic     item_valid = 1'b0;
    logic     item_ready;
    in_item_t item       = '0;
    logic     rec_valid;
    logic     rec_ready  = 1'b0;
    result_t  rec;

    bit      calm         = 1'b0;
    int      failures     = 0;
    int      record_count = 0;
    int      cycle_count  = 0;
    result_t wanted_record;

    request_t requests[$];
    result_t  fresh_records[$];
    result_t  expected_records[$];

    logic [15:0] pos_q      = '0;
    logic [15:0] len_q      = '0;
    logic [15:0] next_off_q = '0;
    logic [2:0]  class_q    = '0;
    logic [7:0]  opt_type_q = '0;
    bit          walking    = 1'b0;

    icmpv6_message_option_parser_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec        (rec)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit idle_roll();
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    function automatic logic [15:0] header_bytes(logic [7:0] t);
        case (t)
            TYPE_RS:       return 16'd8;
            TYPE_RA:       return 16'd16;
            TYPE_NS:       return 16'd24;
            TYPE_NA:       return 16'd24;
            TYPE_REDIRECT: return 16'd40;
            default:       return 16'd0;
        endcase
    endfunction

    function automatic logic [7:0] pick_nd_type();
        return TYPE_RS + 8'($urandom_range(4));
    endfunction

    function automatic result_t message_rec(logic [2:0] status, logic [7:0] t,
                                            logic [15:0] poff, logic [15:0] plen);
        result_t r;
        r                = '0;
        r.record_kind    = KIND_MESSAGE;
        r.message_status = status;
        r.message_type   = t;
        r.payload_offset = poff;
        r.payload_length = plen;
        return r;
    endfunction

    function automatic result_t closing_rec(logic [1:0] why);
        result_t r;
        r             = '0;
        r.record_kind = KIND_END;
        r.end_reason  = why;
        r.last_result = 1'b1;
        return r;
    endfunction

    function automatic bit same_record(result_t a, result_t b);
        return a.record_kind === b.record_kind && a.message_status === b.message_status
            && a.message_type === b.message_type && a.payload_offset === b.payload_offset
            && a.payload_length === b.payload_length && a.option_type === b.option_type
            && a.option_offset === b.option_offset && a.option_length === b.option_length
            && a.end_reason === b.end_reason && a.last_result === b.last_result;
    endfunction

    function automatic string describe(result_t r);
        return $sformatf({"kind %0d status %0d type %0d poff %0d plen %0d",
                          " otype %0d ooff %0d olen %0d reason %0d last %0d"},
                         r.record_kind, r.message_status, r.message_type, r.payload_offset,
                         r.payload_length, r.option_type, r.option_offset, r.option_length,
                         r.end_reason, r.last_result);
    endfunction

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= SHOWN_MISMATCHES)
            $display("%s", msg);
    endfunction

    task automatic close_walk(logic [1:0] why);
        walking = 1'b0;
        fresh_records.push_back(closing_rec(why));
    endtask

    task automatic advance_parser(in_item_t it);
        logic [15:0] hdr;
        logic [15:0] rem;
        logic [15:0] olen;
        logic [7:0]  b;
        result_t     r;
        b   = it.data_byte;
        hdr = header_bytes(b);
        if (it.first_byte)
        begin
            pos_q   = '0;
            len_q   = it.message_length;
            walking = 1'b0;
            r       = message_rec(STATUS_PAYLOAD, b, '0, '0);
            if (len_q < MIN_MESSAGE_BYTES)
                class_q = STATUS_SHORT_MIN;
            else if ((b >= TYPE_ERR_FIRST && b <= TYPE_ERR_LAST) || b == TYPE_ECHO_REQ
                     || b == TYPE_ECHO_REPLY)
            begin
                if (len_q < UNIT_BYTES)
                    class_q = STATUS_SHORT_HEADER;
                else
                begin
                    class_q          = STATUS_PAYLOAD;
                    r.payload_offset = UNIT_BYTES;
                    r.payload_length = len_q - UNIT_BYTES;
                end
            end
            else if (hdr != 0)
            begin
                if (len_q < hdr)
                    class_q = STATUS_SHORT_HEADER;
                else
                begin
                    class_q    = STATUS_OPTIONS;
                    next_off_q = hdr;
                    walking    = 1'b1;
                end
            end
            else
                class_q = STATUS_UNSUPPORTED;
            r.message_status = class_q;
            fresh_records.push_back(r);
            if (!walking || len_q - next_off_q < MIN_OPTION_ROOM || it.last_byte)
                close_walk(REASON_NONE);
        end
        else
        begin
            if (pos_q != POS_MAX)
                pos_q = pos_q + 16'd1;
            if (walking)
            begin
                if (pos_q == next_off_q)
                    opt_type_q = b;
                else if ({1'b0, pos_q} == {1'b0, next_off_q} + 17'd1)
                begin
                    rem  = len_q - next_off_q;
                    olen = {5'd0, b, 3'd0};
                    if (b == 8'd0)
                        close_walk(REASON_ZERO);
                    else if (olen > rem)
                        close_walk(REASON_OVERRUN);
                    else
                    begin
                        r               = '0;
                        r.record_kind   = KIND_OPTION;
                        r.option_type   = opt_type_q;
                        r.option_offset = next_off_q;
                        r.option_length = olen[10:0];
                        fresh_records.push_back(r);
                        next_off_q = next_off_q + olen;
                        if (len_q - next_off_q < MIN_OPTION_ROOM)
                            close_walk(REASON_NONE);
                    end
                end
                if (it.last_byte && walking)
                    close_walk(REASON_NONE);
            end
        end
    endtask

    function automatic in_item_t make_item(logic [7:0] b, bit first, bit last, logic [15:0] len);
        in_item_t it;
        it.data_byte      = b;
        it.first_byte     = first;
        it.last_byte      = last;
        it.message_length = len;
        return it;
    endfunction

    task automatic add_typed(in_item_t it, int n, result_t a, result_t b);
        request_t r;
        r.item  = it;
        r.typed = 1'b1;
        r.count = n[1:0];
        r.rec0  = a;
        r.rec1  = b;
        requests.push_back(r);
    endtask

    task automatic add_checked(in_item_t it);
        request_t r;
        r      = '0;
        r.item = it;
        requests.push_back(r);
    endtask

    task automatic build_directed();
        add_typed(make_item(8'hFF, 1'b0, 1'b1, 16'hFFFF), 0, '0, '0);
        add_typed(make_item(8'h00, 1'b1, 1'b0, 16'h0000), 2,
                  message_rec(STATUS_SHORT_MIN, 8'h00, '0, '0), closing_rec(REASON_NONE));
        add_typed(make_item(8'hFF, 1'b1, 1'b1, 16'hFFFF), 2,
                  message_rec(STATUS_UNSUPPORTED, 8'hFF, '0, '0), closing_rec(REASON_NONE));
        add_typed(make_item(TYPE_ERR_FIRST, 1'b1, 1'b0, UNIT_BYTES - 16'd1), 2,
                  message_rec(STATUS_SHORT_HEADER, TYPE_ERR_FIRST, '0, '0),
                  closing_rec(REASON_NONE));
        add_typed(make_item(TYPE_ERR_LAST, 1'b1, 1'b0, UNIT_BYTES), 2,
                  message_rec(STATUS_PAYLOAD, TYPE_ERR_LAST, UNIT_BYTES, 16'd0),
                  closing_rec(REASON_NONE));
        add_typed(make_item(TYPE_ECHO_REQ, 1'b1, 1'b0, 16'hFFFF), 2,
                  message_rec(STATUS_PAYLOAD, TYPE_ECHO_REQ, UNIT_BYTES, 16'hFFF7),
                  closing_rec(REASON_NONE));
        add_typed(make_item(TYPE_ECHO_REPLY, 1'b1, 1'b0, 16'd3), 2,
                  message_rec(STATUS_SHORT_MIN, TYPE_ECHO_REPLY, '0, '0),
                  closing_rec(REASON_NONE));
        add_typed(make_item(TYPE_ERR_FIRST + 8'd1, 1'b1, 1'b0, MIN_MESSAGE_BYTES), 2,
                  message_rec(STATUS_SHORT_HEADER, TYPE_ERR_FIRST + 8'd1, '0, '0),
                  closing_rec(REASON_NONE));
        add_typed(make_item(TYPE_ECHO_REPLY + 8'd1, 1'b1, 1'b0, 16'd100), 2,
                  message_rec(STATUS_UNSUPPORTED, TYPE_ECHO_REPLY + 8'd1, '0, '0),
                  closing_rec(REASON_NONE));
        add_typed(make_item(TYPE_RS - 8'd1, 1'b1, 1'b0, 16'd100), 2,
                  message_rec(STATUS_UNSUPPORTED, TYPE_RS - 8'd1, '0, '0),
                  closing_rec(REASON_NONE));
        add_typed(make_item(TYPE_REDIRECT + 8'd1, 1'b1, 1'b1, 16'd100), 2,
                  message_rec(STATUS_UNSUPPORTED, TYPE_REDIRECT + 8'd1, '0, '0),
                  closing_rec(REASON_NONE));
        add_typed(make_item(TYPE_REDIRECT, 1'b1, 1'b0, 16'd39), 2,
                  message_rec(STATUS_SHORT_HEADER, TYPE_REDIRECT, '0, '0),
                  closing_rec(REASON_NONE));
        add_typed(make_item(TYPE_RS, 1'b1, 1'b0, 16'd9), 2,
                  message_rec(STATUS_OPTIONS, TYPE_RS, '0, '0), closing_rec(REASON_NONE));
        add_typed(make_item(TYPE_RA, 1'b1, 1'b1, 16'd100), 2,
                  message_rec(STATUS_OPTIONS, TYPE_RA, '0, '0), closing_rec(REASON_NONE));
        add_typed(make_item(TYPE_NS, 1'b1, 1'b0, 16'hFFFF), 1,
                  message_rec(STATUS_OPTIONS, TYPE_NS, '0, '0), '0);
        add_typed(make_item(TYPE_NA, 1'b1, 1'b0, 16'd24), 2,
                  message_rec(STATUS_OPTIONS, TYPE_NA, '0, '0), closing_rec(REASON_NONE));
        // last byte arrives inside the fixed header
        add_checked(make_item(TYPE_RS, 1'b1, 1'b0, 16'd16));
        add_checked(make_item(8'h00, 1'b0, 1'b0, 16'h0000));
        add_checked(make_item(8'hFF, 1'b0, 1'b0, 16'hFFFF));
        add_checked(make_item(8'h5A, 1'b0, 1'b0, 16'h5A5A));
        add_checked(make_item(8'hA5, 1'b0, 1'b1, 16'hA5A5));
        // new message abandons a walk, then a stray byte
        add_checked(make_item(TYPE_RS, 1'b1, 1'b0, 16'd64));
        add_checked(make_item(8'h01, 1'b0, 1'b0, 16'h0000));
        add_checked(make_item(TYPE_ECHO_REQ, 1'b1, 1'b0, 16'd12));
        add_checked(make_item(8'h00, 1'b0, 1'b1, 16'h0000));
    endtask

    task automatic queue_walk_message();
        logic [7:0] body[$];
        logic [7:0] kind;
        int         units;
        int         declared;
        int         sent;
        bit         mark_last;
        kind = pick_nd_type();
        body.push_back(kind);
        repeat (header_bytes(kind) - 1)
            body.push_back(8'($urandom_range(255)));
        repeat ($urandom_range(3))
        begin
            units = ($urandom_range(7) == 0) ? $urandom_range(8, 4) : $urandom_range(3, 1);
            body.push_back(8'($urandom_range(255)));
            body.push_back(8'(units));
            repeat (units * UNIT_BYTES - 2)
                body.push_back(8'($urandom_range(255)));
        end
        case ($urandom_range(9))
            0:
            begin
                // zero-length option
                body.push_back(8'($urandom_range(255)));
                body.push_back(8'd0);
                declared = body.size() + $urandom_range(6);
            end
            1:
            begin
                // option runs past the declared length
                units = $urandom_range(4, 1);
                body.push_back(8'($urandom_range(255)));
                body.push_back(8'(units));
                declared = body.size() - 2 + $urandom_range(units * UNIT_BYTES - 1, 2);
            end
            2:
                declared = body.size() + $urandom_range(9, 2);
            default:
                declared = body.size() + $urandom_range(1);
        endcase
        while (body.size() < declared)
            body.push_back(8'($urandom_range(255)));
        sent      = declared;
        mark_last = 1'b1;
        case ($urandom_range(9))
            0:
                sent = $urandom_range(declared, 1);
            1:
            begin
                sent      = $urandom_range(declared, 1);
                mark_last = 1'b0;
            end
            default:
                ;
        endcase
        for (int i = 0; i < sent; i++)
            add_checked(make_item(body[i], i == 0, mark_last && i == sent - 1,
                                  (i == 0) ? 16'(declared) : 16'($urandom_range(65535))));
    endtask

    task automatic queue_brief_message();
        logic [7:0]  kind;
        logic [15:0] declared;
        int          extra;
        bit          mark_last;
        case ($urandom_range(3))
            0:       kind = TYPE_ERR_FIRST + 8'($urandom_range(3));
            1:       kind = ($urandom_range(1) == 0) ? TYPE_ECHO_REQ : TYPE_ECHO_REPLY;
            2:       kind = pick_nd_type();
            default: kind = 8'($urandom_range(255));
        endcase
        declared  = ($urandom_range(1) == 0) ? 16'($urandom_range(48))
                                             : 16'($urandom_range(65535));
        extra     = $urandom_range(5);
        mark_last = $urandom_range(4) != 0;
        add_checked(make_item(kind, 1'b1, mark_last && extra == 0, declared));
        for (int i = 1; i <= extra; i++)
            add_checked(make_item(8'($urandom_range(255)), 1'b0, mark_last && i == extra,
                                  16'($urandom_range(65535))));
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(6, 1))
            add_checked(make_item(8'($urandom_range(255)), $urandom_range(3) == 0,
                                  1'($urandom_range(1)), 16'($urandom_range(65535))));
    endtask

    task automatic build_random();
        int start;
        int pick;
        start = requests.size();
        while (requests.size() - start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                queue_walk_message();
            else if (pick < 85)
                queue_brief_message();
            else
                queue_noise();
        end
    endtask

    task automatic take_request(request_t r);
        fresh_records.delete();
        advance_parser(r.item);
        if (r.typed)
        begin
            if (r.count > 0)
                expected_records.push_back(r.rec0);
            if (r.count > 1)
                expected_records.push_back(r.rec1);
        end
        else
            foreach (fresh_records[k])
                expected_records.push_back(fresh_records[k]);
    endtask

    always @(posedge clk)
        rec_ready <= calm || !idle_roll();

    always @(posedge clk)
    begin
        if (rst_n && rec_valid && rec_ready)
        begin
            record_count++;
            if (expected_records.size() == 0)
                note_failure($sformatf("unexpected record %0d: %s", record_count,
                                       describe(rec)));
            else
            begin
                wanted_record = expected_records.pop_front();
                if (!same_record(wanted_record, rec))
                    note_failure($sformatf("record %0d mismatch: expected %s, got %s",
                                           record_count, describe(wanted_record),
                                           describe(rec)));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d records outstanding", cycle_count,
                     expected_records.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        build_directed();
        build_random();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        foreach (requests[i])
        begin
            calm = (i >= CALM_FIRST && i < CALM_LAST);
            if (!calm && idle_roll())
            begin
                item_valid <= 1'b0;
                @(posedge clk);
                while (idle_roll())
                    @(posedge clk);
            end
            item_valid <= 1'b1;
            item       <= requests[i].item;
            @(posedge clk);
            while (!item_ready)
                @(posedge clk);
            take_request(requests[i]);
        end
        item_valid <= 1'b0;
        calm = 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && expected_records.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
